### design/ccid_pkg.sv
`timescale 1ns / 1ps

package ccid_pkg;

   localparam int unsigned CellW       = 15;
   localparam int unsigned RelW        = 13;
   localparam int unsigned CellLimit   = 8736;
   localparam int unsigned BarrelFirst = 1152;
   localparam int unsigned BwdFirst    = 7776;
   localparam int unsigned BarrelPhi   = 144;
   localparam int unsigned FwdRings    = 13;
   localparam int unsigned BwdRings    = 10;
   localparam int unsigned EcRings     = FwdRings + BwdRings;
   localparam int unsigned BwdRing0    = 59;
   localparam int unsigned RingIdxW    = $clog2(EcRings);

   typedef enum logic [1:0] {
      REGION_FWD = 2'd0,
      REGION_BAR = 2'd1,
      REGION_BWD = 2'd2
   } region_type;

   typedef logic [9:0] ec_start_type [EcRings];
   typedef logic [3:0] ec_per_type   [EcRings];
   typedef logic [7:0] ec_shape_type [EcRings];

   // Ring start within its endcap, crystals per sector, first shape of the ring.
   localparam ec_start_type EcStart = '{
      10'd0,   10'd48,  10'd96,  10'd160, 10'd224, 10'd288, 10'd384,
      10'd480, 10'd576, 10'd672, 10'd768, 10'd864, 10'd1008,
      10'd0,   10'd144, 10'd288, 10'd384, 10'd480, 10'd576, 10'd672,
      10'd768, 10'd832, 10'd896
   };

   localparam ec_per_type EcPer = '{
      4'd3, 4'd3, 4'd4, 4'd4, 4'd4, 4'd6, 4'd6, 4'd6, 4'd6, 4'd6, 4'd6, 4'd9, 4'd9,
      4'd9, 4'd9, 4'd6, 4'd6, 4'd6, 4'd6, 4'd6, 4'd4, 4'd4, 4'd4
   };

   localparam ec_shape_type EcShape0 = '{
      8'd0,   8'd3,   8'd6,   8'd10,  8'd14,  8'd18,  8'd24,
      8'd30,  8'd36,  8'd42,  8'd48,  8'd54,  8'd63,
      8'd72,  8'd81,  8'd90,  8'd96,  8'd102, 8'd108, 8'd114,
      8'd120, 8'd124, 8'd128
   };

endpackage

### design/crystal_cell_id_decoder.sv
`timescale 1ns / 1ps

// An accepted request is registered through stages 1 to 5; stage 5 drives rsp_valid.
// Throughput: one transaction per cycle; the five stages advance together and
// hold while rsp_valid is high and rsp_ready is low.
// Reset: synchronous, active high; clears every stage valid bit. Payload
// registers are not reset.
module crystal_cell_id_decoder (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [14:0] req_cell_id,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [6:0]  rsp_theta_ring,
   output logic [7:0]  rsp_phi_number,
   output logic [5:0]  rsp_ring_index,
   output logic [7:0]  rsp_shape_index,
   output logic        rsp_out_of_range
);

   localparam int unsigned RW = ccid_pkg::RelW;
   localparam int unsigned IW = ccid_pkg::RingIdxW;

   logic advance;

   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;

   // stage 1
   logic                   oor1_in, oor1_ff;
   ccid_pkg::region_type   reg1_in, reg1_ff;
   logic [RW-1:0]          rel1_in, rel1_ff;

   // stage 2
   logic                   oor2_ff;
   ccid_pkg::region_type   reg2_ff;
   logic [RW-1:0]          rel2_ff;
   logic [IW-1:0]          idx2_in, idx2_ff;
   logic [5:0]             bring2_in, bring2_ff;
   logic [14:0]            bprod2;

   // stage 3
   logic                   oor3_ff;
   ccid_pkg::region_type   reg3_ff;
   logic [7:0]             loc3_in, loc3_ff;
   logic [3:0]             per3_in, per3_ff;
   logic [7:0]             shp3_in, shp3_ff;
   logic [6:0]             theta3_in, theta3_ff;
   logic [5:0]             bring3_ff;
   logic [RW-1:0]          bmul3;
   logic [9:0]             ecloc3;

   // stage 4
   logic                   oor4_ff;
   ccid_pkg::region_type   reg4_ff;
   logic [7:0]             loc4_ff;
   logic [3:0]             per4_ff;
   logic [7:0]             shp4_ff;
   logic [6:0]             theta4_ff;
   logic [5:0]             bring4_ff;
   logic [5:0]             q4_in, q4_ff;
   logic [15:0]            qprod4;

   // stage 5
   logic [6:0]             theta5_in, theta5_ff;
   logic [7:0]             phi5_in, phi5_ff;
   logic [5:0]             ring5_in, ring5_ff;
   logic [7:0]             shape5_in, shape5_ff;
   logic                   oor5_ff;
   logic [7:0]             qn5;
   logic [3:0]             rem5;

   assign advance   = !v5_ff || rsp_ready;
   assign req_ready = advance;

   // stage 1: range check and region split
   always_comb begin
      logic [13:0] mag;
      mag     = req_cell_id[13:0];
      oor1_in = req_cell_id[14] || (mag >= 14'(ccid_pkg::CellLimit));
      if (mag < 14'(ccid_pkg::BarrelFirst)) begin
         reg1_in = ccid_pkg::REGION_FWD;
         rel1_in = mag[RW-1:0];
      end else if (mag < 14'(ccid_pkg::BwdFirst)) begin
         reg1_in = ccid_pkg::REGION_BAR;
         rel1_in = RW'(mag - 14'(ccid_pkg::BarrelFirst));
      end else begin
         reg1_in = ccid_pkg::REGION_BWD;
         rel1_in = RW'(mag - 14'(ccid_pkg::BwdFirst));
      end
   end

   // stage 2: endcap ring search, barrel ring by reciprocal of 9 on rel / 16
   always_comb begin
      if (reg1_ff == ccid_pkg::REGION_BWD) begin
         idx2_in = IW'(ccid_pkg::FwdRings);
         for (int k = ccid_pkg::FwdRings + 1; k < ccid_pkg::EcRings; k++) begin
            if (rel1_ff >= RW'(ccid_pkg::EcStart[k])) begin
               idx2_in = IW'(k);
            end
         end
      end else begin
         idx2_in = '0;
         for (int k = 1; k < ccid_pkg::FwdRings; k++) begin
            if (rel1_ff >= RW'(ccid_pkg::EcStart[k])) begin
               idx2_in = IW'(k);
            end
         end
      end
      bprod2    = 15'(rel1_ff[RW-1:4]) * 15'd57;
      bring2_in = bprod2[14:9];
   end

   // stage 3: position within ring and ring attributes
   always_comb begin
      bmul3  = (RW'(bring2_ff) << 7) + (RW'(bring2_ff) << 4);
      ecloc3 = rel2_ff[9:0] - ccid_pkg::EcStart[idx2_ff];
      if (reg2_ff == ccid_pkg::REGION_BAR) begin
         loc3_in   = 8'(rel2_ff - bmul3);
         theta3_in = 7'(bring2_ff) + 7'(ccid_pkg::FwdRings);
      end else begin
         loc3_in = ecloc3[7:0];
         if (reg2_ff == ccid_pkg::REGION_BWD) begin
            theta3_in = 7'(idx2_ff) + 7'(ccid_pkg::BwdRing0 - ccid_pkg::FwdRings);
         end else begin
            theta3_in = 7'(idx2_ff);
         end
      end
      per3_in = ccid_pkg::EcPer[idx2_ff];
      shp3_in = ccid_pkg::EcShape0[idx2_ff];
   end

   // stage 4: sector number by reciprocal multiply, or by shift for four per sector
   always_comb begin
      q4_in  = '0;
      qprod4 = '0;
      case (per3_ff)
         4'd3: begin
            qprod4 = 16'(loc3_ff) * 16'd171;
            q4_in  = qprod4[14:9];
         end
         4'd4: begin
            q4_in = loc3_ff[7:2];
         end
         4'd6: begin
            qprod4 = 16'(loc3_ff[7:1]) * 16'd171;
            q4_in  = qprod4[14:9];
         end
         4'd9: begin
            qprod4 = 16'(loc3_ff) * 16'd57;
            q4_in  = qprod4[14:9];
         end
         default: begin
            q4_in = '0;
         end
      endcase
   end

   // stage 5: remainder, shape and output select
   always_comb begin
      case (per4_ff)
         4'd3:    qn5 = (8'(q4_ff) << 1) + 8'(q4_ff);
         4'd4:    qn5 = 8'(q4_ff) << 2;
         4'd6:    qn5 = (8'(q4_ff) << 2) + (8'(q4_ff) << 1);
         4'd9:    qn5 = (8'(q4_ff) << 3) + 8'(q4_ff);
         default: qn5 = '0;
      endcase
      rem5 = 4'(loc4_ff - qn5);
      if (oor4_ff) begin
         theta5_in = '0;
         phi5_in   = '0;
         ring5_in  = '0;
         shape5_in = '0;
      end else if (reg4_ff == ccid_pkg::REGION_BAR) begin
         theta5_in = theta4_ff;
         phi5_in   = loc4_ff;
         ring5_in  = bring4_ff;
         shape5_in = loc4_ff;
      end else begin
         theta5_in = theta4_ff;
         phi5_in   = loc4_ff;
         ring5_in  = q4_ff;
         shape5_in = shp4_ff + 8'(rem5);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else if (advance) begin
         v1_ff <= req_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         oor1_ff   <= oor1_in;
         reg1_ff   <= reg1_in;
         rel1_ff   <= rel1_in;

         oor2_ff   <= oor1_ff;
         reg2_ff   <= reg1_ff;
         rel2_ff   <= rel1_ff;
         idx2_ff   <= idx2_in;
         bring2_ff <= bring2_in;

         oor3_ff   <= oor2_ff;
         reg3_ff   <= reg2_ff;
         loc3_ff   <= loc3_in;
         per3_ff   <= per3_in;
         shp3_ff   <= shp3_in;
         theta3_ff <= theta3_in;
         bring3_ff <= bring2_ff;

         oor4_ff   <= oor3_ff;
         reg4_ff   <= reg3_ff;
         loc4_ff   <= loc3_ff;
         per4_ff   <= per3_ff;
         shp4_ff   <= shp3_ff;
         theta4_ff <= theta3_ff;
         bring4_ff <= bring3_ff;
         q4_ff     <= q4_in;

         oor5_ff   <= oor4_ff;
         theta5_ff <= theta5_in;
         phi5_ff   <= phi5_in;
         ring5_ff  <= ring5_in;
         shape5_ff <= shape5_in;
      end
   end

   assign rsp_valid        = v5_ff;
   assign rsp_theta_ring   = theta5_ff;
   assign rsp_phi_number   = phi5_ff;
   assign rsp_ring_index   = ring5_ff;
   assign rsp_shape_index  = shape5_ff;
   assign rsp_out_of_range = oor5_ff;

endmodule
